// ===== sv/tss_pkg.sv =====
// Shared types, codes and constants of the timed step sequencer.
package tss_pkg;

	localparam int MAX_STEPS_DEF = 16;
	localparam int OUT_DEPTH     = 3;
	localparam int IDX_W         = 5;

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_START = 3'd1,
		CMD_PAUSE = 3'd2,
		CMD_STOP  = 3'd3,
		CMD_ADD   = 3'd4,
		CMD_CLEAR = 3'd5
	} cmd_t;

	localparam logic [1:0] OUTC_END   = 2'd0;
	localparam logic [1:0] OUTC_ABORT = 2'd1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RESUMED = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic        has_action;
		logic [31:0] step_delay;
		logic [31:0] repeat_count;
		logic [1:0]  step_outcome;
		logic [31:0] time_ms;
		cmd_t        func;
	} item_t;

	// Packed so that the last field lands in the lowest bits.
	typedef struct packed {
		logic [IDX_W-1:0] step_total;
		logic [1:0]       status;
		logic             running;
		logic [IDX_W-1:0] step_index;
		logic             fired;
	} result_t;

	typedef struct packed {
		logic        act;
		logic [31:0] dly;
		logic [31:0] reps;
	} step_entry_t;

endpackage

// ===== sv/timed_step_sequencer_unit.sv =====
// Top level of the timed step sequencer: ports, step table RAM and result queue.
//
// The sequencer takes one request per clock cycle while s_tready is high and returns
// exactly one result for each, in order, on the master side after the core stage and
// the result queue. The step table (repeat count, delay, action flag per step) lives
// in a synchronous RAM whose read port is always aimed at the step that the next
// request will see, so a tick finds its step entry ready; a step added on the cycle
// before is forwarded around the RAM. A three-entry result queue lets requests keep
// flowing while results wait; the slave side stalls only when that queue and the
// stage in flight would overflow. The table needs no clearing after reset or a clear
// request: entries beyond the step count are never used.
module timed_step_sequencer_unit #(
	parameter int MAX_STEPS = tss_pkg::MAX_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// time_ms [31:0], step_outcome [33:32], repeat_count [65:34],
	// step_delay [97:66], has_action [98], zero fill [103:99]
	input  logic [103:0] s_tdata,
	// func [2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// fired [0], step_index [5:1], running [6], status [8:7], step_total [13:9],
	// zero fill [15:14]
	output logic [15:0]  m_tdata
);

	localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int EW = $bits(tss_pkg::step_entry_t);
	localparam int LW = $clog2(tss_pkg::OUT_DEPTH + 1);
	localparam int RW = $bits(tss_pkg::result_t);

	tss_pkg::item_t   item;
	logic             take;
	logic             tbl_we;
	logic [AW-1:0]    tbl_waddr;
	logic [EW-1:0]    tbl_wdata;
	logic [AW-1:0]    tbl_raddr;
	logic [EW-1:0]    tbl_rdata;
	logic             res_valid;
	tss_pkg::result_t res;
	tss_pkg::result_t head;
	logic [LW-1:0]    level;
	logic             not_empty;

	assign item.func         = tss_pkg::cmd_t'(s_tuser);
	assign item.time_ms      = s_tdata[31:0];
	assign item.step_outcome = s_tdata[33:32];
	assign item.repeat_count = s_tdata[65:34];
	assign item.step_delay   = s_tdata[97:66];
	assign item.has_action   = s_tdata[98];

	// Queue entries plus the request in flight must leave room for one more.
	assign s_tready = ({1'b0, level} + {{LW{1'b0}}, res_valid}) < (LW + 1)'(tss_pkg::OUT_DEPTH);
	assign take     = s_tvalid && s_tready;

	tss_core #(
		.MAX_STEPS(MAX_STEPS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_take   (take),
		.in_item   (item),
		.tbl_we    (tbl_we),
		.tbl_waddr (tbl_waddr),
		.tbl_wdata (tbl_wdata),
		.tbl_raddr (tbl_raddr),
		.tbl_rdata (tbl_rdata),
		.res_valid (res_valid),
		.res       (res)
	);

	tss_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_STEPS)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	tss_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (m_tvalid && m_tready),
		.not_empty (not_empty),
		.level     (level),
		.head      (head)
	);

	assign m_tvalid = not_empty;
	assign m_tdata  = {(16 - RW)'(0), head};

endmodule

// ===== sv/tss_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module tss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/tss_core.sv =====
// Sequencer state, table read-modify pipeline stage and write-to-read bypass.
module tss_core #(
	parameter int MAX_STEPS = tss_pkg::MAX_STEPS_DEF,
	localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1,
	localparam int CW = $clog2(MAX_STEPS + 1),
	localparam int EW = $bits(tss_pkg::step_entry_t)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_take,
	input  tss_pkg::item_t        in_item,
	output logic                  tbl_we,
	output logic [AW-1:0]         tbl_waddr,
	output logic [EW-1:0]         tbl_wdata,
	output logic [AW-1:0]         tbl_raddr,
	input  logic [EW-1:0]         tbl_rdata,
	output logic                  res_valid,
	output tss_pkg::result_t      res
);

	typedef enum logic [1:0] {
		MODE_OFF     = 2'd0,
		MODE_PAUSED  = 2'd1,
		MODE_READY   = 2'd2,
		MODE_WORKING = 2'd3
	} mode_t;

	logic                 valid_s1;
	tss_pkg::item_t       item_s1;
	logic                 byp_hit_s1;
	tss_pkg::step_entry_t byp_data_s1;

	mode_t          mode_q, mode_n;
	logic [CW-1:0]  cur_q, cur_n;
	logic [CW-1:0]  cnt_q, cnt_n;
	logic [31:0]    rc_q, rc_n;
	logic [31:0]    el_q, el_n;
	logic [31:0]    lss_q, lss_n;
	logic [31:0]    lts_q, lts_n;
	logic [31:0]    pt_q, pt_n;

	tss_pkg::step_entry_t entry;
	tss_pkg::step_entry_t wentry;
	logic                 fired;
	logic [CW-1:0]        fidx;
	logic [1:0]           status;

	assign entry = byp_hit_s1 ? byp_data_s1 : tss_pkg::step_entry_t'(tbl_rdata);

	always_comb begin
		logic        valid;
		logic        go_on;
		logic [31:0] rc_t;
		logic [31:0] el_t;

		mode_n = mode_q;
		cur_n  = cur_q;
		cnt_n  = cnt_q;
		rc_n   = rc_q;
		el_n   = el_q;
		lss_n  = lss_q;
		lts_n  = lts_q;
		pt_n   = pt_q;
		fired  = 1'b0;
		fidx   = cur_q;
		status = tss_pkg::ST_OK;
		valid  = cur_q < cnt_q;
		go_on  = 1'b1;
		rc_t   = rc_q;
		el_t   = el_q;

		if (valid_s1) begin
			unique case (item_s1.func)
				tss_pkg::CMD_TICK: begin
					unique case (mode_q)
						MODE_OFF: begin
						end
						MODE_PAUSED: begin
							pt_n = pt_q + (item_s1.time_ms - lts_q);
						end
						MODE_READY: begin
							lss_n  = item_s1.time_ms;
							mode_n = MODE_WORKING;
						end
						MODE_WORKING: begin
							if (el_q == 32'd0 || !valid) begin
								if (valid && entry.act) begin
									fired = 1'b1;
									if (item_s1.step_outcome == tss_pkg::OUTC_ABORT) begin
										go_on = 1'b0;
									end else begin
										if (item_s1.step_outcome == tss_pkg::OUTC_END) begin
											rc_t = entry.reps;
										end
										el_t = el_q + 32'd1;
									end
								end else begin
									go_on = 1'b0;
								end
							end
							if (go_on) begin
								if (el_t >= entry.dly) begin
									if (rc_t >= entry.reps) begin
										cur_n = cur_q + CW'(1);
										rc_n  = 32'd0;
									end else begin
										rc_n = rc_t + 32'd1;
									end
									el_n = 32'd0;
								end else begin
									rc_n = rc_t;
									el_n = el_t + (item_s1.time_ms - lss_q);
								end
								lss_n = item_s1.time_ms;
							end else begin
								mode_n = MODE_OFF;
								cur_n  = '0;
								rc_n   = 32'd0;
								lss_n  = 32'd0;
								el_n   = 32'd0;
								pt_n   = 32'd0;
							end
						end
					endcase
					lts_n = item_s1.time_ms;
				end
				tss_pkg::CMD_START: begin
					if (mode_q == MODE_OFF) begin
						mode_n = MODE_READY;
						cur_n  = '0;
						rc_n   = 32'd0;
					end else if (mode_q == MODE_PAUSED) begin
						mode_n = MODE_WORKING;
						lss_n  = lss_q + pt_q;
						status = tss_pkg::ST_RESUMED;
					end else begin
						status = tss_pkg::ST_REFUSED;
					end
				end
				tss_pkg::CMD_PAUSE: begin
					mode_n = MODE_PAUSED;
					pt_n   = 32'd0;
				end
				tss_pkg::CMD_STOP: begin
					mode_n = MODE_OFF;
					cur_n  = '0;
					rc_n   = 32'd0;
					lss_n  = 32'd0;
					el_n   = 32'd0;
					pt_n   = 32'd0;
				end
				tss_pkg::CMD_ADD: begin
					if (cnt_q == CW'(MAX_STEPS)) begin
						status = tss_pkg::ST_FULL;
					end else begin
						cnt_n = cnt_q + CW'(1);
					end
				end
				tss_pkg::CMD_CLEAR: begin
					mode_n = MODE_OFF;
					cur_n  = '0;
					cnt_n  = '0;
					rc_n   = 32'd0;
					lss_n  = 32'd0;
					lts_n  = 32'd0;
					el_n   = 32'd0;
					pt_n   = 32'd0;
				end
				default: begin
				end
			endcase
		end
	end

	// Table write for an add request; the read port already looks up the entry
	// that the next request will see as its current step.
	assign wentry.reps = item_s1.repeat_count;
	assign wentry.dly  = item_s1.step_delay;
	assign wentry.act  = item_s1.has_action;

	assign tbl_we    = valid_s1 && item_s1.func == tss_pkg::CMD_ADD && cnt_q != CW'(MAX_STEPS);
	assign tbl_waddr = cnt_q[AW-1:0];
	assign tbl_wdata = EW'(wentry);
	assign tbl_raddr = cur_n[AW-1:0];

	assign res_valid      = valid_s1;
	assign res.fired      = fired;
	assign res.step_index = fired ? tss_pkg::IDX_W'(fidx) : tss_pkg::IDX_W'(cur_n);
	assign res.running    = mode_n != MODE_OFF;
	assign res.status     = status;
	assign res.step_total = tss_pkg::IDX_W'(cnt_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= MODE_OFF;
			cur_q    <= '0;
			cnt_q    <= '0;
			rc_q     <= 32'd0;
			el_q     <= 32'd0;
			lss_q    <= 32'd0;
			lts_q    <= 32'd0;
			pt_q     <= 32'd0;
		end else begin
			valid_s1 <= in_take;
			mode_q   <= mode_n;
			cur_q    <= cur_n;
			cnt_q    <= cnt_n;
			rc_q     <= rc_n;
			el_q     <= el_n;
			lss_q    <= lss_n;
			lts_q    <= lts_n;
			pt_q     <= pt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_item;
		end
		// A write to the very entry being read this cycle is forwarded.
		byp_hit_s1  <= tbl_we && (cur_n == cnt_q);
		byp_data_s1 <= wentry;
	end

endmodule

// ===== sv/tss_out_fifo.sv =====
// Small result queue that decouples the sequencer from the output handshake.
module tss_out_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tss_pkg::result_t      push_data,
	input  logic                  pop,
	output logic                  not_empty,
	output logic [$clog2(tss_pkg::OUT_DEPTH+1)-1:0] level,
	output tss_pkg::result_t      head
);

	localparam int PW = $clog2(tss_pkg::OUT_DEPTH);
	localparam int LW = $clog2(tss_pkg::OUT_DEPTH + 1);

	tss_pkg::result_t buf_q [tss_pkg::OUT_DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [LW-1:0]    cnt_q;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(tss_pkg::OUT_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign not_empty = cnt_q != '0;
	assign level     = cnt_q;
	assign head      = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wrap_inc(wr_q);
			end
			if (pop) begin
				rd_q <= wrap_inc(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + LW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= push_data;
		end
	end

endmodule
